FILE: design/ffza_pkg.sv
// shared types, constants and codes of the first-fit zone allocator
`default_nettype none

package ffza_pkg;

  localparam int WORD_W = 32;
  localparam int ADDR_BITS = 32;
  localparam int MAX_BLOCKS_DEF = 128;

  // top of the address space, 2^min(ADDR_BITS, 32)
  localparam logic [WORD_W:0] SPACE_LIMIT =
    (ADDR_BITS >= WORD_W) ? {1'b1, {WORD_W{1'b0}}} : ((WORD_W + 1)'(1) << ADDR_BITS);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_LENGTH = 1'b1;

  localparam logic [1:0] STAT_GRANT = 2'd0;
  localparam logic [1:0] STAT_NOSPACE = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_END,
    ST_EMPTY,
    ST_CAND,
    ST_NEXT,
    ST_LAST,
    ST_SHIFT,
    ST_PLACE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic              cin;
    logic [WORD_W:0]   cmp;
  } alu_in_t;

  typedef struct packed {
    logic [WORD_W:0] sum;
    logic            le;
    logic            ge;
  } alu_out_t;

endpackage

`default_nettype wire

FILE: design/ffza_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module ffza_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: design/ffza_alu.sv
// shared adder with compare against a bound
`default_nettype none

module ffza_alu
  import ffza_pkg::*;
(
  input  wire alu_in_t  op_i,
  output      alu_out_t res_o
);

  logic [WORD_W:0] sum;

  always_comb begin
    sum = {1'b0, op_i.a} + {1'b0, op_i.b} + {{WORD_W{1'b0}}, op_i.cin};
    res_o.sum = sum;
    res_o.le = (sum <= op_i.cmp);
    res_o.ge = (sum >= op_i.cmp);
  end

endmodule

`default_nettype wire

FILE: design/first_fit_zone_allocator.sv
// first-fit zone allocator: request sequencer, block table and result register
//
// Each input word on in_* is one allocation request of in_request_size bytes;
// each produces exactly one result word on out_*: out_status (granted, no
// space, table full) and out_block_address (zero unless granted).
// The zone is set through cfg_* (index 0 base, index 1 length); cfg_ready is
// always high. The zone is to be written while no request is in flight; the
// user is bound to this, the block itself has no check for it. A request is
// handled alone: in_stall is high from acceptance until its result has been
// taken. The zone end is clamped first, then the sorted table ram is scanned
// block by block (a candidate step adds block end plus one and a fit step adds
// candidate plus size, each compared on the shared adder), the fitting entry
// and those above it move up one entry per cycle, and the new block is
// written. A full table answers straight after the end clamp.
// Reset empties the table (block count and used bytes cleared, ram left
// as is, no clearing pass) and zeroes both zone registers.
// While out_stall is high the result stays in its output register and
// no new request is taken.
`default_nettype none

module first_fit_zone_allocator
  import ffza_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire logic [WORD_W-1:0]    in_request_size,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      logic [1:0]           out_status,
  output      logic [WORD_W-1:0]    out_block_address,
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int RAM_W = 2 * WORD_W;

  state_t state_r, state_nxt;

  logic [WORD_W-1:0] zone_base_r, zone_len_r;
  logic [WORD_W:0]   zone_end_r, zone_end_nxt;
  logic [WORD_W-1:0] size_r, size_nxt;
  logic [WORD_W-1:0] cand_r, cand_nxt;
  logic [WORD_W-1:0] used_r, used_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [IW-1:0]     pos_r, pos_nxt;
  logic [IW-1:0]     sh_r, sh_nxt;
  logic [IW-1:0]     wdst_r, wdst_nxt;
  logic              pend_r, pend_nxt;
  logic [1:0]        stat_r, stat_nxt;
  logic [WORD_W-1:0] addr_r, addr_nxt;

  logic              ram_wr_en, ram_rd_en;
  logic [IW-1:0]     ram_wr_addr, ram_rd_addr;
  logic [RAM_W-1:0]  ram_wr_data, ram_rd_data;
  logic [WORD_W-1:0] rd_start, rd_len;

  alu_in_t  alu_in;
  alu_out_t alu_out;

  logic in_acc, out_acc, has_next, is_full, is_empty;

  assign rd_start = ram_rd_data[RAM_W-1:WORD_W];
  assign rd_len = ram_rd_data[WORD_W-1:0];
  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign has_next = (CW'(idx_r) + CW'(1)) < count_r;
  assign is_full = (count_r == CW'(MAX_BLOCKS));
  assign is_empty = (count_r == '0);

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_RESP);
  assign out_status = stat_r;
  assign out_block_address = addr_r;
  assign cfg_ready = 1'b1;

  ffza_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  ffza_alu u_alu (
    .op_i  (alu_in),
    .res_o (alu_out)
  );

  // shared adder operands
  always_comb begin
    alu_in = '0;
    case (state_r)
      ST_END: begin
        alu_in.a = zone_base_r;
        alu_in.b = zone_len_r;
        alu_in.cmp = SPACE_LIMIT;
      end
      ST_EMPTY: begin
        alu_in.a = zone_base_r;
        alu_in.b = size_r;
        alu_in.cmp = zone_end_r;
      end
      ST_CAND: begin
        alu_in.a = rd_start;
        alu_in.b = rd_len;
        alu_in.cin = 1'b1;
        alu_in.cmp = zone_end_r;
      end
      ST_NEXT: begin
        alu_in.a = cand_r;
        alu_in.b = size_r;
        alu_in.cmp = {1'b0, rd_start};
      end
      ST_LAST: begin
        alu_in.a = cand_r;
        alu_in.b = size_r;
        alu_in.cmp = zone_end_r;
      end
      ST_PLACE: begin
        alu_in.a = used_r;
        alu_in.b = size_r;
      end
      default: begin
        alu_in = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_END;
        end
      end
      ST_END: begin
        if (is_full) begin
          state_nxt = ST_RESP;
        end else if (is_empty) begin
          state_nxt = ST_EMPTY;
        end else begin
          state_nxt = ST_CAND;
        end
      end
      ST_EMPTY: begin
        state_nxt = alu_out.le ? ST_SHIFT : ST_RESP;
      end
      ST_CAND: begin
        if (alu_out.ge) begin
          state_nxt = ST_RESP;
        end else if (has_next) begin
          state_nxt = ST_NEXT;
        end else begin
          state_nxt = ST_LAST;
        end
      end
      ST_NEXT: begin
        state_nxt = alu_out.le ? ST_SHIFT : ST_CAND;
      end
      ST_LAST: begin
        state_nxt = alu_out.le ? ST_SHIFT : ST_RESP;
      end
      ST_SHIFT: begin
        if (sh_r <= pos_r) begin
          state_nxt = ST_PLACE;
        end
      end
      ST_PLACE: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_acc) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and table control
  always_comb begin
    zone_end_nxt = zone_end_r;
    size_nxt = size_r;
    cand_nxt = cand_r;
    used_nxt = used_r;
    count_nxt = count_r;
    idx_nxt = idx_r;
    pos_nxt = pos_r;
    sh_nxt = sh_r;
    wdst_nxt = wdst_r;
    pend_nxt = pend_r;
    stat_nxt = stat_r;
    addr_nxt = addr_r;
    ram_wr_en = 1'b0;
    ram_wr_addr = '0;
    ram_wr_data = '0;
    ram_rd_en = 1'b0;
    ram_rd_addr = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          size_nxt = in_request_size;
        end
      end
      ST_END: begin
        zone_end_nxt = alu_out.le ? alu_out.sum : SPACE_LIMIT;
        stat_nxt = STAT_FULL;
        addr_nxt = '0;
        idx_nxt = '0;
        ram_rd_en = 1'b1;
      end
      ST_EMPTY: begin
        stat_nxt = STAT_NOSPACE;
        cand_nxt = zone_base_r;
        pos_nxt = '0;
        sh_nxt = '0;
        pend_nxt = 1'b0;
      end
      ST_CAND: begin
        stat_nxt = STAT_NOSPACE;
        cand_nxt = alu_out.sum[WORD_W-1:0];
        if (!alu_out.ge && has_next) begin
          ram_rd_en = 1'b1;
          ram_rd_addr = idx_r + IW'(1);
        end
      end
      ST_NEXT: begin
        idx_nxt = idx_r + IW'(1);
        pos_nxt = idx_r + IW'(1);
        sh_nxt = IW'(count_r);
        pend_nxt = 1'b0;
      end
      ST_LAST: begin
        pos_nxt = IW'(count_r);
        sh_nxt = IW'(count_r);
        pend_nxt = 1'b0;
      end
      ST_SHIFT: begin
        // move entries up one place, read and write overlapped
        if (pend_r) begin
          ram_wr_en = 1'b1;
          ram_wr_addr = wdst_r;
          ram_wr_data = ram_rd_data;
        end
        if (sh_r > pos_r) begin
          ram_rd_en = 1'b1;
          ram_rd_addr = sh_r - IW'(1);
          wdst_nxt = sh_r;
          sh_nxt = sh_r - IW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
      end
      ST_PLACE: begin
        ram_wr_en = 1'b1;
        ram_wr_addr = pos_r;
        ram_wr_data = {cand_r, size_r};
        count_nxt = count_r + CW'(1);
        used_nxt = alu_out.sum[WORD_W-1:0];
        stat_nxt = STAT_GRANT;
        addr_nxt = cand_r;
      end
      default: begin
        stat_nxt = stat_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      used_r <= '0;
      zone_base_r <= '0;
      zone_len_r <= '0;
      pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      used_r <= used_nxt;
      pend_r <= pend_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ZONE_BASE: begin
            zone_base_r <= cfg_data;
          end
          REG_ZONE_LENGTH: begin
            zone_len_r <= cfg_data;
          end
          default: begin
            zone_base_r <= zone_base_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    zone_end_r <= zone_end_nxt;
    size_r <= size_nxt;
    cand_r <= cand_nxt;
    idx_r <= idx_nxt;
    pos_r <= pos_nxt;
    sh_r <= sh_nxt;
    wdst_r <= wdst_nxt;
    stat_r <= stat_nxt;
    addr_r <= addr_nxt;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_BLOCKS))
    else $error("block count beyond table depth");

  a_refused_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_GRANT) |-> out_block_address == '0)
    else $error("refused request carries an address");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall && !out_valid)
    else $error("not busy after taking a request");

  a_place_counts: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PLACE |=> count_r == $past(count_r) + CW'(1))
    else $error("insert did not grow the table");
`endif

endmodule

`default_nettype wire

FILE: verif/ffza_checker.sv
// allocation predictor and result scoreboard for the first-fit zone allocator
module ffza_checker
  import ffza_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_stall,
  input  wire logic [WORD_W-1:0]    in_request_size,
  input  wire logic                 out_valid,
  input  wire logic                 out_stall,
  input  wire logic [1:0]           out_status,
  input  wire logic [WORD_W-1:0]    out_block_address,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data,
  output int                        error_count,
  output int                        pending,
  output int                        granted,
  output int                        refused_space,
  output int                        refused_full
);

  localparam int XW = WORD_W + 2;

  typedef struct packed {
    logic [1:0]        status;
    logic [WORD_W-1:0] address;
  } alloc_result_t;

  logic [WORD_W-1:0] blk_start [MAX_BLOCKS];
  logic [WORD_W-1:0] blk_len [MAX_BLOCKS];
  int                blk_count;
  logic [WORD_W-1:0] bytes_in_use;
  logic [WORD_W-1:0] base_reg;
  logic [WORD_W-1:0] length_reg;
  alloc_result_t     alloc_q[$];

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  // keeps the table sorted by start, ties go in front of the existing entry
  task automatic record_block(input logic [WORD_W-1:0] start, input logic [WORD_W-1:0] len);
    int pos;
    int k;
    pos = 0;
    while (pos < blk_count && blk_start[pos] < start) pos++;
    for (k = blk_count; k > pos; k--) begin
      blk_start[k] = blk_start[k-1];
      blk_len[k] = blk_len[k-1];
    end
    blk_start[pos] = start;
    blk_len[pos] = len;
    blk_count++;
    bytes_in_use = bytes_in_use + len;
  endtask

  task automatic predict_alloc(input logic [WORD_W-1:0] size, output alloc_result_t res);
    logic [XW-1:0] zone_end;
    logic [XW-1:0] cand;
    logic [XW-1:0] bound;
    int            i;
    bit            done;
    res.status = STAT_NOSPACE;
    res.address = '0;
    done = 1'b0;
    zone_end = XW'(base_reg) + XW'(length_reg);
    if (zone_end > XW'(SPACE_LIMIT)) zone_end = XW'(SPACE_LIMIT);
    if (blk_count >= MAX_BLOCKS) begin
      res.status = STAT_FULL;
    end else if (blk_count == 0) begin
      cand = XW'(base_reg);
      if (cand + XW'(size) <= zone_end) begin
        record_block(cand[WORD_W-1:0], size);
        res.status = STAT_GRANT;
        res.address = cand[WORD_W-1:0];
      end
    end else begin
      for (i = 0; i < blk_count && !done; i++) begin
        cand = XW'(blk_start[i]) + XW'(blk_len[i]) + XW'(1);
        if (cand >= zone_end) begin
          done = 1'b1;
        end else begin
          if (i + 1 < blk_count) begin
            bound = XW'(blk_start[i+1]);
          end else begin
            bound = zone_end;
          end
          if (cand + XW'(size) <= bound) begin
            record_block(cand[WORD_W-1:0], size);
            res.status = STAT_GRANT;
            res.address = cand[WORD_W-1:0];
            done = 1'b1;
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin : watch
    alloc_result_t want;
    alloc_result_t got;
    if (!rst_n) begin
      blk_count = 0;
      bytes_in_use = '0;
      base_reg = '0;
      length_reg = '0;
      alloc_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ZONE_BASE:   base_reg = cfg_data;
          REG_ZONE_LENGTH: length_reg = cfg_data;
          default: ;
        endcase
      end
      // a result word can never belong to a request taken on the same edge
      if (out_valid && !out_stall) begin
        if (alloc_q.size() == 0) begin
          report_mismatch($sformatf("result word status %0d address %h with no request waiting",
                                    out_status, out_block_address));
        end else begin
          want = alloc_q.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
          if (out_block_address !== want.address)
            report_mismatch($sformatf("block address %h, expected %h",
                                      out_block_address, want.address));
          case (want.status)
            STAT_GRANT:   granted++;
            STAT_NOSPACE: refused_space++;
            default:      refused_full++;
          endcase
        end
      end
      if (in_valid && !in_stall) begin
        predict_alloc(in_request_size, got);
        alloc_q.push_back(got);
      end
    end
    pending = alloc_q.size();
  end

endmodule

FILE: verif/tb_top.sv
// stimulus, handshake timing and verdict for the first-fit zone allocator
module tb_top
  import ffza_pkg::*;
;

  localparam int MAX_BLOCKS = MAX_BLOCKS_DEF;
  localparam int QUIET_LIMIT = 8000;
  localparam int SETTLE_CYCLES = 3 * MAX_BLOCKS + 16;
  localparam int PHASES = 16;
  localparam int PHASE_ITEMS = 125;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [WORD_W-1:0]    in_request_size;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           out_status;
  logic [WORD_W-1:0]    out_block_address;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  int error_count;
  int pending;
  int granted;
  int refused_space;
  int refused_full;
  int idle_pct;
  int stall_pct;
  int quiet_cycles;
  int requests_sent;
  int zones_set;

  first_fit_zone_allocator #(.MAX_BLOCKS(MAX_BLOCKS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_request_size(in_request_size),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_block_address(out_block_address),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ffza_checker #(.MAX_BLOCKS(MAX_BLOCKS)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_request_size(in_request_size),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_block_address(out_block_address),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .error_count(error_count), .pending(pending), .granted(granted),
    .refused_space(refused_space), .refused_full(refused_full)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // in_valid stays high after acceptance so back-to-back words need no lowering
  task automatic send_request(input logic [WORD_W-1:0] size);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_request_size <= size;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    requests_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
  endtask

  task automatic set_zone(input logic [WORD_W-1:0] base, input logic [WORD_W-1:0] len);
    drain_results();
    write_reg(REG_ZONE_BASE, base);
    write_reg(REG_ZONE_LENGTH, len);
    cfg_valid <= 1'b0;
    zones_set++;
  endtask

  initial begin
    int                phase;
    int                n;
    logic [WORD_W-1:0] base;
    logic [WORD_W-1:0] len;
    logic [WORD_W-1:0] floor_size;
    logic [WORD_W-1:0] size;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_request_size <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_ZONE_BASE;
    cfg_data <= '0;
    stall_pct <= 0;
    idle_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table with the reset zone: oversize first requests
    send_request(32'd1);
    send_request(32'hFFFF_FFFF);
    // zero-length zone: zero-byte grant at base, then candidate past the zone end
    set_zone(32'h0000_1000, 32'h0000_0000);
    send_request(32'd0);
    send_request(32'd0);
    send_request(32'd5);
    // zone end clamped to the address space
    set_zone(32'h0000_1000, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF);
    send_request(32'hFFFF_F000);
    send_request(32'h0000_0100);
    // base moved above the existing blocks
    set_zone(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'd0);
    send_request(32'd1);
    send_request(32'hFFFF_EFFF);
    // exact fit up to the zone end, then no fit
    set_zone(32'h0000_0000, 32'h0000_2000);
    send_request(32'h0000_0EFC);
    send_request(32'd1);
    send_request(32'd0);

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase % 8)
        1: begin
          base = '1;
          len = '1;
          floor_size = 32'hFFFF_F000;
        end
        3, 7: begin
          base = $urandom_range(32'h3FFF_FFFF);
          len = $urandom_range(32'h3FFF_FFFF);
          floor_size = 32'h8000_0000;
        end
        5: begin
          base = '0;
          len = '0;
          floor_size = '0;
        end
        default: begin
          base = $urandom_range(32'h0000_FFFF);
          len = $urandom_range(32'h000F_FFFF, 32'h0000_4000);
          floor_size = 32'h0011_0000;
        end
      endcase
      set_zone(base, len);
      case (phase % 4)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct = 60;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 60;
        end
        default: begin
          idle_pct = 21;
          stall_pct <= 21;
        end
      endcase
      // mostly sizes that cannot fit, so the table fills across the whole run
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(9) == 0)
          size = $urandom_range(255);
        else
          size = $urandom_range(32'hFFFF_FFFF, floor_size);
        send_request(size);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d requests under %0d zone settings with sender gaps and result stalls",
             requests_sent, zones_set);
    $display("results: %0d granted, %0d refused for space, %0d refused with a full table",
             granted, refused_space, refused_full);
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
